[sv/spectrum_bar_falloff_peak_hold_top_macros.svh]
// Assertion macros for the spectrum bar falloff block.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef SPECTRUM_BAR_FALLOFF_PEAK_HOLD_TOP_MACROS_SVH
`define SPECTRUM_BAR_FALLOFF_PEAK_HOLD_TOP_MACROS_SVH
`ifndef SYNTH
`define SBFPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SBFPH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define SBFPH_ASSERT(lbl, prop, msg)
`define SBFPH_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[sv/sbfph_pkg.sv]
// Shared constants and types for the spectrum bar falloff block.
// No dependencies.
package sbfph_pkg;

  localparam int CHANNELS = 2;
  localparam int BINS     = 64;
  localparam int DB_RANGE = 256;
  localparam int ENTRIES  = CHANNELS * BINS;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CH_W     = 1;
  localparam int BIN_W    = 6;
  localparam int DATA_W   = 8;
  localparam int PROD_W   = 2 * DATA_W;

  localparam logic [DATA_W-1:0] HEIGHT_RESET = DATA_W'(64);
  localparam logic [DATA_W-1:0] DATA_MAX     = '1;

  typedef struct packed {
    logic [DATA_W-1:0] show;
    logic [DATA_W-1:0] fall;
    logic [DATA_W-1:0] peak;
  } entry_t;

endpackage

[sv/sbfph_in_if.sv]
// Input channel of the spectrum bar falloff block: one bin sample per transfer.
// Depends on sbfph_pkg.
interface sbfph_in_if;
  logic                            valid;
  logic                            ready;
  logic [sbfph_pkg::CH_W-1:0]      channel;
  logic [sbfph_pkg::BIN_W-1:0]     bin;
  logic [sbfph_pkg::DATA_W-1:0]    raw_level;

  modport source (output valid, channel, bin, raw_level, input ready);
  modport sink   (input valid, channel, bin, raw_level, output ready);
endinterface

[sv/sbfph_out_if.sv]
// Result channel of the spectrum bar falloff block: one updated bar per transfer.
// Depends on sbfph_pkg.
interface sbfph_out_if;
  logic                            valid;
  logic                            ready;
  logic [sbfph_pkg::CH_W-1:0]      out_channel;
  logic [sbfph_pkg::BIN_W-1:0]     out_bin;
  logic [sbfph_pkg::DATA_W-1:0]    level;
  logic [sbfph_pkg::DATA_W-1:0]    previous_level;
  logic [sbfph_pkg::DATA_W-1:0]    peak;
  logic [sbfph_pkg::DATA_W-1:0]    previous_peak;

  modport source (output valid, out_channel, out_bin, level, previous_level, peak,
                  previous_peak, input ready);
  modport sink   (input valid, out_channel, out_bin, level, previous_level, peak,
                  previous_peak, output ready);
endinterface

[sv/sbfph_update.sv]
// Bar decay, rise and peak hold update of one stored entry.
// Depends on sbfph_pkg.
module sbfph_update (
  input  sbfph_pkg::entry_t            entry_i,
  input  logic [sbfph_pkg::DATA_W-1:0] scaled_i,
  output sbfph_pkg::entry_t            entry_o
);

  logic [sbfph_pkg::DATA_W-1:0] show_fall;
  logic [sbfph_pkg::DATA_W-1:0] fall_fall;
  logic [sbfph_pkg::DATA_W-1:0] show_new;
  logic [sbfph_pkg::DATA_W-1:0] fall_new;
  logic [sbfph_pkg::DATA_W-1:0] peak_new;
  logic [sbfph_pkg::DATA_W:0]   show_plus;

  always_comb begin
    show_fall = entry_i.show;
    fall_fall = entry_i.fall;
    if (scaled_i < entry_i.show) begin
      if (entry_i.show >= entry_i.fall) begin
        show_fall = entry_i.show - entry_i.fall;
        fall_fall = (entry_i.fall == sbfph_pkg::DATA_MAX) ? sbfph_pkg::DATA_MAX
                                                          : entry_i.fall + 1'b1;
      end else begin
        show_fall = '0;
      end
    end
  end

  always_comb begin
    show_new = show_fall;
    fall_new = fall_fall;
    if (scaled_i > show_fall) begin
      show_new = scaled_i;
      fall_new = sbfph_pkg::DATA_W'(1);
    end
  end

  assign show_plus = {1'b0, show_new} + 1'b1;

  always_comb begin
    peak_new = entry_i.peak;
    if (entry_i.peak <= scaled_i) begin
      peak_new = (scaled_i == sbfph_pkg::DATA_MAX) ? sbfph_pkg::DATA_MAX
                                                   : scaled_i + 1'b1;
    end else if ((entry_i.peak != '0) && ({1'b0, entry_i.peak} > show_plus)) begin
      peak_new = entry_i.peak - 1'b1;
    end
  end

  always_comb begin
    entry_o.show = show_new;
    entry_o.fall = fall_new;
    entry_o.peak = peak_new;
  end

endmodule

[sv/spectrum_bar_falloff_peak_hold_top.sv]
// Spectrum bar falloff with peak hold.
// Samples arrive on in_i, one bin per transfer, tagged with channel and bin. Each is
// scaled by the display_height register (cfg_we_i / cfg_wdata_i, reset 64) over the
// dB range and folded into that bin's stored level, fall rate and peak.
// Every accepted sample gives exactly one result on out_o: the echoed channel and
// bin, the new and previous level and the new and previous peak. Out-of-range
// addresses give zero fields and leave the store untouched.
// Throughput is one sample per cycle while the receiver is ready; results are
// registered from the sample stage. The limit is the single read-modify-write
// of the entry store, whose read is registered and whose last write is forwarded.
// Reset clears the register to 64 and marks all entries invalid, so they read as
// zero; no clearing pass is needed and samples are taken right after reset.
// When the receiver stalls, the result register holds and the sample stage fills;
// in_i.ready then drops until out_o.ready returns.
// Depends on sbfph_pkg, sbfph_in_if, sbfph_out_if, sbfph_update and the macro header.
`include "spectrum_bar_falloff_peak_hold_top_macros.svh"

module spectrum_bar_falloff_peak_hold_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sbfph_pkg::DATA_W-1:0] cfg_wdata_i,
  sbfph_in_if.sink                     in_i,
  sbfph_out_if.source                  out_o
);

  logic [sbfph_pkg::DATA_W-1:0] height_q;

  logic                          in_fire;
  logic                          in_range;
  logic [sbfph_pkg::IDX_W-1:0]   in_idx;
  logic [sbfph_pkg::PROD_W-1:0]  prod;
  logic [sbfph_pkg::PROD_W-1:0]  quot;
  logic [sbfph_pkg::DATA_W-1:0]  scaled;

  logic                          s1_valid_q;
  logic                          s1_range_q;
  logic [sbfph_pkg::CH_W-1:0]    s1_ch_q;
  logic [sbfph_pkg::BIN_W-1:0]   s1_bin_q;
  logic [sbfph_pkg::IDX_W-1:0]   s1_idx_q;
  logic [sbfph_pkg::DATA_W-1:0]  s1_scaled_q;
  logic                          s1_adv;

  sbfph_pkg::entry_t             mem_q [sbfph_pkg::ENTRIES];
  logic [sbfph_pkg::ENTRIES-1:0] valid_q;
  sbfph_pkg::entry_t             rd_q;
  logic                          rd_vld_q;
  logic                          hit_q;
  sbfph_pkg::entry_t             fwd_q;
  sbfph_pkg::entry_t             cur_entry;
  sbfph_pkg::entry_t             new_entry;
  logic                          wr_en;

  logic                          out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= sbfph_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      height_q <= cfg_wdata_i;
    end
  end

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  assign in_range = (int'(in_i.channel) < sbfph_pkg::CHANNELS) &&
                    (int'(in_i.bin) < sbfph_pkg::BINS);
  assign in_idx   = sbfph_pkg::IDX_W'(int'(in_i.channel) * sbfph_pkg::BINS + int'(in_i.bin));
  assign prod     = sbfph_pkg::PROD_W'(height_q) * sbfph_pkg::PROD_W'(in_i.raw_level);
  assign quot     = sbfph_pkg::PROD_W'(prod / sbfph_pkg::DB_RANGE);
  assign scaled   = (quot > sbfph_pkg::PROD_W'(sbfph_pkg::DATA_MAX)) ? sbfph_pkg::DATA_MAX
                                                                     : quot[sbfph_pkg::DATA_W-1:0];

  assign wr_en = s1_valid_q && s1_range_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_range_q  <= in_range;
      s1_ch_q     <= in_i.channel;
      s1_bin_q    <= in_i.bin;
      s1_idx_q    <= in_idx;
      s1_scaled_q <= scaled;
      rd_q        <= mem_q[in_idx];
      rd_vld_q    <= valid_q[in_idx];
      hit_q       <= wr_en && (s1_idx_q == in_idx);
      fwd_q       <= new_entry;
    end
    if (wr_en) begin
      mem_q[s1_idx_q] <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_idx_q] <= 1'b1;
    end
  end

  always_comb begin
    if (hit_q) begin
      cur_entry = fwd_q;
    end else if (rd_vld_q) begin
      cur_entry = rd_q;
    end else begin
      cur_entry = '0;
    end
  end

  sbfph_update u_update (
    .entry_i  (cur_entry),
    .scaled_i (s1_scaled_q),
    .entry_o  (new_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_o.out_channel <= s1_ch_q;
      out_o.out_bin     <= s1_bin_q;
      if (s1_range_q) begin
        out_o.level          <= new_entry.show;
        out_o.previous_level <= cur_entry.show;
        out_o.peak           <= new_entry.peak;
        out_o.previous_peak  <= cur_entry.peak;
      end else begin
        out_o.level          <= '0;
        out_o.previous_level <= '0;
        out_o.peak           <= '0;
        out_o.previous_peak  <= '0;
      end
    end
  end

  assign out_o.valid = out_valid_q;

  `SBFPH_ASSERT(a_level_covers_sample, (s1_valid_q && s1_range_q) |-> (new_entry.show >= s1_scaled_q), "New level is below the scaled sample.")
  `SBFPH_ASSERT_NEXT(a_write_marks_valid, wr_en, valid_q[$past(s1_idx_q)], "Written entry is not marked valid.")
  `SBFPH_ASSERT(a_result_from_stage, $rose(out_valid_q) |-> $past(s1_valid_q), "Result appeared without a sample in the stage.")

endmodule

[tb/spectrum_bar_falloff_peak_hold_top_tb.sv]
// Self-checking testbench for the spectrum bar falloff block with peak hold.
// Drives bin samples through a directed table, then random rise and decay runs; checks
// each result against a table row or bar model. Depends on sbfph_pkg and both interfaces.
`timescale 1ns / 100ps

module spectrum_bar_falloff_peak_hold_top_tb;

  typedef struct packed {
    logic [sbfph_pkg::CH_W-1:0]   ch;
    logic [sbfph_pkg::BIN_W-1:0]  bin;
    logic [sbfph_pkg::DATA_W-1:0] level;
    logic [sbfph_pkg::DATA_W-1:0] prev_level;
    logic [sbfph_pkg::DATA_W-1:0] peak;
    logic [sbfph_pkg::DATA_W-1:0] prev_peak;
  } bar_t;

  typedef struct packed {
    logic [sbfph_pkg::DATA_W-1:0] height;
    logic [sbfph_pkg::CH_W-1:0]   ch;
    logic [sbfph_pkg::BIN_W-1:0]  bin;
    logic [sbfph_pkg::DATA_W-1:0] raw;
    logic                         typed;
    bar_t                         want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd64, 1'b0, 6'd0, 8'd0, 1'b1, '{1'b0, 6'd0, 8'd0, 8'd0, 8'd1, 8'd0}},
    '{8'd64, 1'b1, 6'd63, 8'd255, 1'b1, '{1'b1, 6'd63, 8'd63, 8'd0, 8'd64, 8'd0}},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b1, '{1'b1, 6'd63, 8'd62, 8'd63, 8'd63, 8'd64}},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b1, 6'd63, 8'd0, 1'b0, '0},
    '{8'd64, 1'b0, 6'd1, 8'd128, 1'b0, '0},
    '{8'd64, 1'b0, 6'd1, 8'd200, 1'b0, '0},
    '{8'd64, 1'b0, 6'd1, 8'd100, 1'b0, '0},
    '{8'd64, 1'b0, 6'd1, 8'd200, 1'b0, '0},
    '{8'd64, 1'b1, 6'd0, 8'd255, 1'b0, '0},
    '{8'd64, 1'b0, 6'd63, 8'd1, 1'b0, '0},
    '{8'd64, 1'b0, 6'd32, 8'd4, 1'b0, '0},
    '{8'd255, 1'b0, 6'd2, 8'd255, 1'b1, '{1'b0, 6'd2, 8'd254, 8'd0, 8'd255, 8'd0}},
    '{8'd255, 1'b0, 6'd2, 8'd255, 1'b1, '{1'b0, 6'd2, 8'd254, 8'd254, 8'd255, 8'd255}},
    '{8'd0, 1'b0, 6'd2, 8'd255, 1'b0, '0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [sbfph_pkg::DATA_W-1:0] cfg_wdata_i;

  sbfph_in_if  in_ch ();
  sbfph_out_if res_ch ();

  spectrum_bar_falloff_peak_hold_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (res_ch)
  );

  logic [sbfph_pkg::DATA_W-1:0] display_h = sbfph_pkg::HEIGHT_RESET;
  logic [sbfph_pkg::DATA_W-1:0] bar_show [sbfph_pkg::ENTRIES] = '{default: '0};
  logic [sbfph_pkg::DATA_W-1:0] bar_fall [sbfph_pkg::ENTRIES] = '{default: '0};
  logic [sbfph_pkg::DATA_W-1:0] bar_peak [sbfph_pkg::ENTRIES] = '{default: '0};

  bar_t pending_bars [$];
  bar_t front_bar;
  int   fails = 0;
  bit   calm = 1'b0;

  function automatic int unsigned sat_byte(input int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic bar_t update_bar(input logic [sbfph_pkg::CH_W-1:0] ch,
                                      input logic [sbfph_pkg::BIN_W-1:0] bin,
                                      input logic [sbfph_pkg::DATA_W-1:0] raw);
    int unsigned idx;
    int unsigned scaled;
    int unsigned show;
    int unsigned fall;
    int unsigned pk;
    bar_t        r;
    idx = 32'(ch) * 32'(sbfph_pkg::BINS) + 32'(bin);
    scaled = sat_byte((32'(display_h) * 32'(raw)) / 32'(sbfph_pkg::DB_RANGE));
    show = 32'(bar_show[idx]);
    fall = 32'(bar_fall[idx]);
    pk = 32'(bar_peak[idx]);
    r.ch = ch;
    r.bin = bin;
    r.prev_level = sbfph_pkg::DATA_W'(show);
    r.prev_peak = sbfph_pkg::DATA_W'(pk);
    if (scaled < show) begin
      if (show >= fall) begin
        show = show - fall;
        fall = sat_byte(fall + 1);
      end else begin
        show = 0;
      end
    end
    if (scaled > show) begin
      show = scaled;
      fall = 1;
    end
    if (pk <= scaled) begin
      pk = sat_byte(scaled + 1);
    end else if (pk != 0 && pk > show + 1) begin
      pk = pk - 1;
    end
    bar_show[idx] = sbfph_pkg::DATA_W'(show);
    bar_fall[idx] = sbfph_pkg::DATA_W'(fall);
    bar_peak[idx] = sbfph_pkg::DATA_W'(pk);
    r.level = sbfph_pkg::DATA_W'(show);
    r.peak = sbfph_pkg::DATA_W'(pk);
    return r;
  endfunction

  task automatic send_sample(input logic [sbfph_pkg::CH_W-1:0] ch,
                             input logic [sbfph_pkg::BIN_W-1:0] bin,
                             input logic [sbfph_pkg::DATA_W-1:0] raw, input logic typed,
                             input bar_t want);
    bar_t got;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.channel <= ch;
    in_ch.bin <= bin;
    in_ch.raw_level <= raw;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    got = update_bar(ch, bin, raw);
    pending_bars.push_back(typed ? want : got);
  endtask

  task automatic drain_pending();
    while (pending_bars.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_height(input logic [sbfph_pkg::DATA_W-1:0] h);
    in_ch.valid <= 1'b0;
    drain_pending();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    display_h = h;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_bars.size() == 0) begin
        $error("result transfer with no sample pending: channel %0d bin %0d",
               res_ch.out_channel, res_ch.out_bin);
        fails++;
      end else begin
        front_bar = pending_bars.pop_front();
        if (res_ch.out_channel !== front_bar.ch) begin
          $error("out_channel: expected %0d, got %0d", front_bar.ch, res_ch.out_channel);
          fails++;
        end
        if (res_ch.out_bin !== front_bar.bin) begin
          $error("out_bin: expected %0d, got %0d", front_bar.bin, res_ch.out_bin);
          fails++;
        end
        if (res_ch.level !== front_bar.level) begin
          $error("level: expected %0d, got %0d", front_bar.level, res_ch.level);
          fails++;
        end
        if (res_ch.previous_level !== front_bar.prev_level) begin
          $error("previous_level: expected %0d, got %0d", front_bar.prev_level,
                 res_ch.previous_level);
          fails++;
        end
        if (res_ch.peak !== front_bar.peak) begin
          $error("peak: expected %0d, got %0d", front_bar.peak, res_ch.peak);
          fails++;
        end
        if (res_ch.previous_peak !== front_bar.prev_peak) begin
          $error("previous_peak: expected %0d, got %0d", front_bar.prev_peak,
                 res_ch.previous_peak);
          fails++;
        end
      end
    end
  end

  initial begin
    logic [sbfph_pkg::CH_W-1:0]   hot_ch;
    logic [sbfph_pkg::BIN_W-1:0]  hot_base;
    logic [sbfph_pkg::CH_W-1:0]   ch;
    logic [sbfph_pkg::BIN_W-1:0]  bin;
    logic [sbfph_pkg::DATA_W-1:0] strike;
    logic [sbfph_pkg::DATA_W-1:0] h;
    int                           sent;
    int                           tail;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.bin = '0;
    in_ch.raw_level = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].height != display_h) write_height(DIRECTED[r].height);
      send_sample(DIRECTED[r].ch, DIRECTED[r].bin, DIRECTED[r].raw, DIRECTED[r].typed,
                  DIRECTED[r].want);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: h = 8'd1;
        2: h = 8'd255;
        4: h = 8'd0;
        5: h = 8'd128;
        default: h = sbfph_pkg::DATA_W'($urandom_range(0, 255));
      endcase
      write_height(h);
      calm = (p == 7);
      hot_ch = sbfph_pkg::CH_W'($urandom_range(0, 1));
      hot_base = sbfph_pkg::BIN_W'($urandom_range(0, 63));
      sent = 0;
      while (sent < 112) begin
        if ($urandom_range(0, 4) == 0) begin
          send_sample(sbfph_pkg::CH_W'($urandom_range(0, 1)),
                      sbfph_pkg::BIN_W'($urandom_range(0, 63)),
                      sbfph_pkg::DATA_W'($urandom_range(0, 255)), 1'b0, '0);
          sent++;
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            ch = sbfph_pkg::CH_W'($urandom_range(0, 1));
            bin = sbfph_pkg::BIN_W'($urandom_range(0, 63));
          end else begin
            ch = hot_ch;
            bin = sbfph_pkg::BIN_W'(hot_base + $urandom_range(0, 3));
          end
          strike = sbfph_pkg::DATA_W'($urandom_range(0, 255));
          send_sample(ch, bin, strike, 1'b0, '0);
          tail = int'($urandom_range(2, 14));
          repeat (tail) begin
            send_sample(ch, bin, sbfph_pkg::DATA_W'($urandom_range(0, strike / 2)), 1'b0,
                        '0);
          end
          sent += tail + 1;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("spectrum_bar_falloff_peak_hold_top_tb: done, clean");
    end else begin
      $display("spectrum_bar_falloff_peak_hold_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("spectrum_bar_falloff_peak_hold_top_tb: done, errors");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/sbfph_pkg.sv
sv/sbfph_in_if.sv
sv/sbfph_out_if.sv
sv/sbfph_update.sv
sv/spectrum_bar_falloff_peak_hold_top.sv
tb/spectrum_bar_falloff_peak_hold_top_tb.sv
